// ----- src/lvpr_pkg.sv -----
// Shared constants, types and helper functions of the local variance pixel reject core.
// Used by every module under src but lvpr_line_mem; it depends on nothing else.
`default_nettype none

package lvpr_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int PIXEL_BITS_DEF = 16;

  // Fixed field widths of the stream words
  localparam int VALUE_BITS   = 16;
  localparam int ROW_BITS     = 12;
  localparam int OUT_COL_BITS = 9;
  localparam int IN_DATA_BITS = 16;
  localparam int OUT_DATA_BITS = 40;

  // Frame geometry arithmetic is done at this width (holds up to 4096 and beyond)
  localparam int DIM_BITS   = 13;
  localparam int HEIGHT_MAX = 4096;
  localparam int DIM_MIN    = 3;

  // Configuration registers
  localparam int LIMIT_BITS     = 31;
  localparam int FWIDTH_BITS    = 10;
  localparam int FHEIGHT_BITS   = 13;
  localparam int CFG_DATA_BITS  = 31;
  localparam int CFG_INDEX_BITS = 2;
  localparam int LIMIT81_BITS   = 38;

  localparam logic [CFG_INDEX_BITS-1:0] REG_VARIANCE_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT   = 2'd2;

  localparam logic [LIMIT_BITS-1:0]   VARIANCE_LIMIT_RST = 31'd3000;
  localparam logic [FWIDTH_BITS-1:0]  FRAME_WIDTH_RST    = 10'd320;
  localparam logic [FHEIGHT_BITS-1:0] FRAME_HEIGHT_RST   = 13'd240;

  // Position of the pixel just accepted, in the form the output needs
  typedef struct packed {
    logic [ROW_BITS-1:0]     row_out;   // row of the window centre
    logic [OUT_COL_BITS-1:0] col_out;   // column of the window centre
    logic                    interior;  // full 3x3 window available
    logic                    last;      // last interior pixel of the frame
  } pos_t;

  // Side information carried along the variance pipeline
  typedef struct packed {
    logic [ROW_BITS-1:0]     row;
    logic [OUT_COL_BITS-1:0] col;
    logic [VALUE_BITS-1:0]   centre;
    logic                    last;
  } meta_t;

  // One finished result word
  typedef struct packed {
    logic [ROW_BITS-1:0]     row;
    logic [OUT_COL_BITS-1:0] col;
    logic [VALUE_BITS-1:0]   value;
    logic                    rejected;
    logic                    last;
  } res_t;

  // Clamp a frame dimension into [DIM_MIN, hi]
  function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                    input logic [DIM_BITS-1:0] hi);
    logic [DIM_BITS-1:0] r;
    r = v;
    if (v < DIM_BITS'(DIM_MIN)) r = DIM_BITS'(DIM_MIN);
    else if (v > hi) r = hi;
    return r;
  endfunction

  // 81 * limit by shifts and adds
  function automatic logic [LIMIT81_BITS-1:0] times81(input logic [LIMIT_BITS-1:0] v);
    logic [LIMIT81_BITS-1:0] x;
    x = LIMIT81_BITS'(v);
    return (x << 6) + (x << 4) + x;
  endfunction

endpackage

`default_nettype wire

// ----- src/local_variance_pixel_reject_core.sv -----
// Local variance pixel reject core: 3x3 variance outlier filter on a depth stream.
// Uses lvpr_pkg, lvpr_position, lvpr_line_mem and lvpr_variance.
`default_nettype none

// Takes one depth pixel per clock in raster order while the skid stage is empty
// and, once the pixel below and to the right of a centre has arrived, emits that
// interior centre with its row and column: the value passes unchanged, or is
// forced to 0 and flagged when 9*sum(sq) - sum^2 of its 3x3 neighbourhood
// exceeds 81 * variance_limit. Border pixels give no output. Throughput is one
// pixel per clock while the output is not stalled; the single line memory serves
// one read and one write per cycle (a back-to-back hit on the same column is
// forwarded). A result passes stage 1, the variance pipeline and the output
// register. The line memory is not cleared after reset; only the frame geometry
// decides when its contents are used. Configuration is taken at any time the
// core is idle and applies from the next pixel on. Out-of-range widths and
// heights are clamped to 3..MAX_WIDTH and 3..4096.
module local_variance_pixel_reject_core #(
  parameter int MAX_WIDTH  = lvpr_pkg::MAX_WIDTH_DEF,
  parameter int PIXEL_BITS = lvpr_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // configuration write port
  input  wire logic                                  cfg_we,
  input  wire logic [lvpr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [lvpr_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  // pixel input
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  input  wire logic [lvpr_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,  // [15:0] pixel
  input  wire logic                                  s_axis_tuser,  // [0] frame_start
  // filtered output
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  output logic      [lvpr_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata,  // [11:0] out_row,
                                                                    // [20:12] out_col,
                                                                    // [36:21] out_value,
                                                                    // [39:37] zero
  output logic                                       m_axis_tuser,  // [0] rejected
  output logic                                       m_axis_tlast   // frame_end
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int P        = PIXEL_BITS;
  localparam int DB       = lvpr_pkg::DIM_BITS;
  localparam int VB       = lvpr_pkg::VALUE_BITS;
  localparam int LB       = 2 * P + 8;
  localparam int CB       = (LB > lvpr_pkg::LIMIT81_BITS) ? LB : lvpr_pkg::LIMIT81_BITS;

  // Configuration state
  logic [lvpr_pkg::LIMIT81_BITS-1:0] limit81;
  logic [DB-1:0]                     width_eff;
  logic [DB-1:0]                     height_eff;

  logic en, accept;
  lvpr_pkg::pos_t      pos;
  logic [COL_BITS-1:0] addr;

  // Stage 1: memory read data present
  logic                v1;
  lvpr_pkg::pos_t      pos1;
  logic [COL_BITS-1:0] addr1;
  logic [P-1:0]        px1;
  logic                fwd1;
  logic [P-1:0]        fwd_mid, fwd_px;
  logic [2*P-1:0]      rd_data;
  logic [P-1:0]        top_eff, mid_eff;
  logic [5:0][P-1:0]   wreg;
  logic [8:0][P-1:0]   win;
  lvpr_pkg::meta_t     meta1;

  // Pipeline end and output
  logic                vd;
  logic [LB-1:0]       lhs_d;
  lvpr_pkg::meta_t     meta_d;
  lvpr_pkg::res_t      res, out_res, skid_res;
  logic                skid_valid;
  logic                rej;

  // Register writes; effective sizes and 81*limit are kept ready
  always_ff @(posedge clk) begin
    if (rst) begin
      limit81    <= lvpr_pkg::times81(lvpr_pkg::VARIANCE_LIMIT_RST);
      width_eff  <= lvpr_pkg::clamp_dim(DB'(lvpr_pkg::FRAME_WIDTH_RST), DB'(MAX_WIDTH));
      height_eff <= lvpr_pkg::clamp_dim(DB'(lvpr_pkg::FRAME_HEIGHT_RST),
                                        DB'(lvpr_pkg::HEIGHT_MAX));
    end else if (cfg_we) begin
      unique case (cfg_index)
        lvpr_pkg::REG_VARIANCE_LIMIT: begin
          limit81 <= lvpr_pkg::times81(cfg_data[lvpr_pkg::LIMIT_BITS-1:0]);
        end
        lvpr_pkg::REG_FRAME_WIDTH: begin
          width_eff <= lvpr_pkg::clamp_dim(DB'(cfg_data[lvpr_pkg::FWIDTH_BITS-1:0]),
                                           DB'(MAX_WIDTH));
        end
        lvpr_pkg::REG_FRAME_HEIGHT: begin
          height_eff <= lvpr_pkg::clamp_dim(DB'(cfg_data[lvpr_pkg::FHEIGHT_BITS-1:0]),
                                            DB'(lvpr_pkg::HEIGHT_MAX));
        end
        default: begin
        end
      endcase
    end
  end

  // The whole pipeline moves unless the skid stage is occupied
  assign en            = !skid_valid;
  assign s_axis_tready = en;
  assign accept        = s_axis_tvalid && s_axis_tready;

  lvpr_position #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_position (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .frame_start (s_axis_tuser),
    .width_eff   (width_eff),
    .height_eff  (height_eff),
    .pos         (pos),
    .addr        (addr)
  );

  // Line word: upper half is two rows up, lower half is the row above
  lvpr_line_mem #(
    .DEPTH     (MAX_WIDTH),
    .DATA_BITS (2 * P)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (en && v1),
    .wr_addr (addr1),
    .wr_data ({mid_eff, px1}),
    .rd_en   (en),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  // Forward the previous word when it wrote the column being read
  assign top_eff = fwd1 ? fwd_mid : rd_data[2*P-1:P];
  assign mid_eff = fwd1 ? fwd_px  : rd_data[P-1:0];

  // Stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      fwd1 <= 1'b0;
    end else if (en) begin
      v1   <= accept;
      fwd1 <= accept && v1 && (addr == addr1);
    end
  end

  // Stage 1 payload and forwarding copy
  always_ff @(posedge clk) begin
    if (en) begin
      pos1    <= pos;
      addr1   <= addr;
      px1     <= s_axis_tdata[P-1:0];
      fwd_mid <= mid_eff;
      fwd_px  <= px1;
    end
  end

  // Shift the two previous columns of the window
  always_ff @(posedge clk) begin
    if (rst) begin
      wreg <= '0;
    end else if (en && v1) begin
      wreg[0] <= wreg[1];
      wreg[1] <= top_eff;
      wreg[2] <= wreg[3];
      wreg[3] <= mid_eff;
      wreg[4] <= wreg[5];
      wreg[5] <= px1;
    end
  end

  // Assemble the 3x3 window, top row first
  always_comb begin
    win[0] = wreg[0];
    win[1] = wreg[1];
    win[2] = top_eff;
    win[3] = wreg[2];
    win[4] = wreg[3];
    win[5] = mid_eff;
    win[6] = wreg[4];
    win[7] = wreg[5];
    win[8] = px1;
    meta1.row    = pos1.row_out;
    meta1.col    = pos1.col_out;
    meta1.centre = VB'(win[4]);
    meta1.last   = pos1.last;
  end

  lvpr_variance #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_variance (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v1 && pos1.interior),
    .win       (win),
    .in_meta   (meta1),
    .out_valid (vd),
    .out_lhs   (lhs_d),
    .out_meta  (meta_d)
  );

  // Decide and form the result word
  always_comb begin
    rej          = CB'(lhs_d) > CB'(limit81);
    res.row      = meta_d.row;
    res.col      = meta_d.col;
    res.value    = rej ? '0 : meta_d.centre;
    res.rejected = rej;
    res.last     = meta_d.last;
  end

  // Output register with one skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        m_axis_tvalid <= en && vd;
      end
    end else if (en && vd) begin
      if (!m_axis_tvalid) begin
        m_axis_tvalid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (en && vd) begin
      if (!m_axis_tvalid) begin
        out_res <= res;
      end else begin
        skid_res <= res;
      end
    end
  end

  assign m_axis_tdata = {3'b000, out_res.value, out_res.col, out_res.row};
  assign m_axis_tuser = out_res.rejected;
  assign m_axis_tlast = out_res.last;

  // The skid stage is only ever filled behind a waiting output word
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid stage full while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid stage filled without an output stall");

  // Forwarding only follows a word that was in stage 1 the cycle before
  a_fwd_needs_item: assert property (@(posedge clk) disable iff (rst)
    fwd1 |-> v1)
    else $error("forwarding flagged without a word in stage 1");

endmodule

`default_nettype wire

// ----- src/lvpr_line_mem.sv -----
// Line memory holding the two previous rows side by side in one word.
// Simple dual port: one write and one registered read per cycle; no package use.
`default_nettype none

module lvpr_line_mem #(
  parameter int DEPTH     = 512,
  parameter int DATA_BITS = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [DATA_BITS-1:0]     wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [DATA_BITS-1:0]     rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- src/lvpr_position.sv -----
// Raster position tracker: row and column of each accepted pixel, with wrap.
// Depends on lvpr_pkg for the dimension width and the position type.
`default_nettype none

module lvpr_position #(
  parameter int MAX_WIDTH = lvpr_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 accept,
  input  wire logic                                 frame_start,
  input  wire logic [lvpr_pkg::DIM_BITS-1:0]        width_eff,
  input  wire logic [lvpr_pkg::DIM_BITS-1:0]        height_eff,
  output lvpr_pkg::pos_t                            pos,
  output logic      [$clog2(MAX_WIDTH)-1:0]         addr
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int DB       = lvpr_pkg::DIM_BITS;
  localparam int RB       = lvpr_pkg::ROW_BITS;
  localparam int OCB      = lvpr_pkg::OUT_COL_BITS;

  logic [RB-1:0]       row;
  logic [COL_BITS-1:0] col;
  logic [RB-1:0]       row_next;
  logic [COL_BITS-1:0] col_next;

  logic [DB-1:0] col_base, row_base, row_wrap;
  logic [DB-1:0] c, r, c_inc, r_inc, r_dec, c_dec;

  // Place the incoming pixel, wrapping a position left beyond a changed size
  always_comb begin
    col_base = frame_start ? '0 : DB'(col);
    row_base = frame_start ? '0 : DB'(row);
    c        = col_base;
    row_wrap = row_base;
    if (col_base >= width_eff) begin
      c        = '0;
      row_wrap = row_base + DB'(1);
    end
    r = (row_wrap >= height_eff) ? '0 : row_wrap;

    c_inc = c + DB'(1);
    r_inc = r + DB'(1);
    if (c_inc >= width_eff) begin
      col_next = '0;
      row_next = (r_inc >= height_eff) ? '0 : r_inc[RB-1:0];
    end else begin
      col_next = c_inc[COL_BITS-1:0];
      row_next = r[RB-1:0];
    end

    r_dec        = r - DB'(1);
    c_dec        = c - DB'(1);
    pos.row_out  = r_dec[RB-1:0];
    pos.col_out  = c_dec[OCB-1:0];
    pos.interior = (r >= DB'(2)) && (c >= DB'(2));
    pos.last     = (r == height_eff - DB'(1)) && (c == width_eff - DB'(1));
    addr         = c[COL_BITS-1:0];
  end

  // Advance the counters on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
      col <= '0;
    end else if (accept) begin
      row <= row_next;
      col <= col_next;
    end
  end

endmodule

`default_nettype wire

// ----- src/lvpr_variance.sv -----
// Variance pipeline: squares and sum, partial sums, total, then 9*Q - S*S.
// Depends on lvpr_pkg for the side-information type.
`default_nettype none

module lvpr_variance #(
  parameter int PIXEL_BITS = lvpr_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            en,
  input  wire logic                            in_valid,
  input  wire logic [8:0][PIXEL_BITS-1:0]      win,
  input  wire lvpr_pkg::meta_t                 in_meta,
  output logic                                 out_valid,
  output logic      [2*PIXEL_BITS+7:0]         out_lhs,
  output lvpr_pkg::meta_t                      out_meta
);

  localparam int SQB = 2 * PIXEL_BITS;
  localparam int SB  = PIXEL_BITS + 4;
  localparam int Q3B = SQB + 2;
  localparam int QB  = SQB + 4;
  localparam int LB  = SQB + 8;

  logic [SB-1:0] s_sum;
  logic [8:0][SQB-1:0] sq;

  logic                 va, vb, vc;
  logic [8:0][SQB-1:0]  sq_a;
  logic [SB-1:0]        s_a;
  lvpr_pkg::meta_t      meta_a, meta_b, meta_c;
  logic [2:0][Q3B-1:0]  q3_b;
  logic [LB-1:0]        ss_b, ss_c;
  logic [QB-1:0]        q_c;
  logic [LB-1:0]        lhs;

  // Squares and plain sum of the nine samples
  always_comb begin
    s_sum = '0;
    for (int k = 0; k < 9; k++) begin
      sq[k] = SQB'(win[k]) * SQB'(win[k]);
      s_sum = s_sum + SB'(win[k]);
    end
  end

  // 9*Q - S*S, never negative
  assign lhs = LB'({q_c, 3'b000}) + LB'(q_c) - ss_c;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      va        <= in_valid;
      vb        <= va;
      vc        <= vb;
      out_valid <= vc;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      sq_a   <= sq;
      s_a    <= s_sum;
      meta_a <= in_meta;

      for (int j = 0; j < 3; j++) begin
        q3_b[j] <= Q3B'(sq_a[3*j]) + Q3B'(sq_a[3*j+1]) + Q3B'(sq_a[3*j+2]);
      end
      ss_b   <= LB'(s_a) * LB'(s_a);
      meta_b <= meta_a;

      q_c    <= QB'(q3_b[0]) + QB'(q3_b[1]) + QB'(q3_b[2]);
      ss_c   <= ss_b;
      meta_c <= meta_b;

      out_lhs  <= lhs;
      out_meta <= meta_c;
    end
  end

endmodule

`default_nettype wire
